// ----- src/ctp_pkg.sv -----
// Shared types, codes and character helpers for the cost table text parser.
// No dependencies; the parser unit imports this package.
package ctp_pkg;

    typedef enum logic [4:0] {
        PH_HDR_PREFIX, PH_HDR_VERSION, PH_HDR_REST, PH_LINE_START,
        PH_SKIP_LINE, PH_CLASS_PREFIX,
        PH_CID, PH_RECIP_SIGN, PH_RECIP_WHOLE, PH_RECIP_FRAC, PH_SKIP1, PH_UOPS,
        PH_SKIP2, PH_MICRO, PH_SKIP3, PH_FUSE, PH_SKIP4, PH_SKIP5, PH_LAT_SCAN,
        PH_LAT_SIGN, PH_LAT_WHOLE, PH_LAT_FRAC, PH_CLASS_TAIL,
        PH_MAP_FORM, PH_MAP_CLASS, PH_MAP_TAIL, PH_FAILED
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CLASS  = 2'd0,
        KIND_MAP    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_SPACE   = 2'd2;

    localparam logic [1:0] CFG_VERSION    = 2'd0;
    localparam logic [1:0] CFG_CLASS_CAP  = 2'd1;
    localparam logic [1:0] CFG_FORM_CAP   = 2'd2;

    localparam logic [31:0] VERSION_DEFAULT   = 32'd1;
    localparam logic [15:0] CLASS_CAP_DEFAULT = 16'd1024;
    localparam logic [16:0] FORM_CAP_DEFAULT  = 17'd4096;

    localparam logic [2:0]  MAGIC_LEN      = 3'd7;
    localparam logic [2:0]  CLASS_WORD_LEN = 3'd6;
    localparam logic [2:0]  COLON_MAX      = 3'd4;
    localparam logic [2:0]  LAT_COLON      = 3'd3;
    localparam logic [1:0]  FRAC_DIGITS    = 2'd3;
    localparam logic [31:0] MILLI          = 32'd1000;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] index;
        logic [15:0] mapped_class;
        logic [31:0] recip_throughput_milli;
        logic [15:0] uop_count;
        logic        microcoded;
        logic        macro_fusible;
        logic [31:0] latency_milli;
        logic [15:0] class_total;
        logic [31:0] mapping_total;
    } result_t;

    // header magic, seven bytes
    function automatic logic [7:0] hdr_magic(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h76;
            3'd1:    ch = 8'h78;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h72;
            3'd4:    ch = 8'h63;
            3'd5:    ch = 8'h68;
            3'd6:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // "class " keyword
    function automatic logic [7:0] class_word(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h63;
            3'd1:    ch = 8'h6C;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [31:0] mul10_add(input logic [31:0] a, input logic [3:0] d);
        return {a[28:0], 3'b000} + {a[30:0], 1'b0} + {28'd0, d};
    endfunction

    function automatic logic in_line(input phase_t p);
        return (p >= PH_SKIP_LINE) && (p <= PH_MAP_TAIL);
    endfunction

endpackage

// ----- src/ctp_if.sv -----
// Handshake channels of the cost table text parser: text in, results out, config writes.
// Depends on nothing.
interface ctp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;
    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ctp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] index;
    logic [15:0] mapped_class;
    logic [31:0] recip_throughput_milli;
    logic [15:0] uop_count;
    logic        microcoded;
    logic        macro_fusible;
    logic [31:0] latency_milli;
    logic [15:0] class_total;
    logic [31:0] mapping_total;
    modport source (output valid, kind, status, index, mapped_class, recip_throughput_milli,
                    uop_count, microcoded, macro_fusible, latency_milli, class_total,
                    mapping_total, input ready);
    modport sink   (input valid, kind, status, index, mapped_class, recip_throughput_milli,
                    uop_count, microcoded, macro_fusible, latency_milli, class_total,
                    mapping_total, output ready);
endinterface

interface ctp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cost_table_text_parser_unit.sv -----
// Cost table text parser: one text byte per word, class/mapping records and a final status.
// Results of an accepted byte are registered into the output buffer, behind any results already queued.
// Throughput: one byte per cycle; a byte yields up to two results, which queue in a
// four-entry output buffer; ready drops while fewer than two entries are free.
// Reset: parse state returns to header start, config registers to their defaults.
// Depends on ctp_pkg and the interfaces in ctp_if.sv.
module cost_table_text_parser_unit
    import ctp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    ctp_text_if.sink       text,
    ctp_result_if.source   result,
    ctp_cfg_if.sink        cfg
);

    // config
    logic [31:0] version_reg;
    logic [15:0] class_cap_reg;
    logic [16:0] form_cap_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [2:0]  mpos_reg, mpos_next;
    logic [2:0]  colon_reg, colon_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] milli_reg, milli_next;
    logic [1:0]  fpos_reg, fpos_next;
    logic        neg_reg, neg_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] recip_reg, recip_next;
    logic [15:0] uops_reg, uops_next;
    logic [1:0]  flags_reg, flags_next;
    logic [31:0] best_reg, best_next;
    logic [15:0] high_reg, high_next;
    logic [31:0] mapcnt_reg, mapcnt_next;
    logic [1:0]  err_reg, err_next;

    // output buffer
    result_t     fifo_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  push_cnt;
    result_t     rec, stat;
    logic        rec_valid, stat_valid;

    logic        accept, pop;
    logic        go, do_end, dig;
    logic [7:0]  c;
    logic [3:0]  d;
    logic [31:0] mv;
    logic [31:0] frac_add;
    logic [16:0] id_plus1;

    assign cfg.ready  = 1'b1;
    assign text.ready = (cnt_reg <= 3'd2);
    assign accept     = text.valid && text.ready;
    assign pop        = result.valid && result.ready;

    assign c   = text.text_byte;
    assign dig = (c >= CH_ZERO) && (c <= CH_NINE);
    assign d   = dig ? 4'(c - CH_ZERO) : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= VERSION_DEFAULT;
            class_cap_reg <= CLASS_CAP_DEFAULT;
            form_cap_reg  <= FORM_CAP_DEFAULT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_VERSION:   version_reg   <= cfg.data;
                CFG_CLASS_CAP: class_cap_reg <= cfg.data[15:0];
                CFG_FORM_CAP:  form_cap_reg  <= cfg.data[16:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        mpos_next   = mpos_reg;
        colon_next  = colon_reg;
        num_next    = num_reg;
        milli_next  = milli_reg;
        fpos_next   = fpos_reg;
        neg_next    = neg_reg;
        line_next   = line_reg;
        recip_next  = recip_reg;
        uops_next   = uops_reg;
        flags_next  = flags_reg;
        best_next   = best_reg;
        high_next   = high_reg;
        mapcnt_next = mapcnt_reg;
        err_next    = err_reg;
        go          = 1'b0;
        do_end      = 1'b0;
        mv          = '0;
        id_plus1    = '0;
        rec_valid   = 1'b0;
        stat_valid  = 1'b0;
        rec         = '0;
        stat        = '0;
        case (fpos_reg)
            2'd0:    frac_add = 32'(d) * 32'd100;
            2'd1:    frac_add = 32'(d) * 32'd10;
            default: frac_add = 32'(d);
        endcase

        if (accept)
        begin
            go = 1'b1;
            if (in_line(phase_next) && c == CH_NL)
            begin
                do_end = 1'b1;
                go     = 1'b0;
            end

            // phases are visited in chain order, so one pass covers a fall-through
            if (go && phase_next == PH_HDR_PREFIX)
            begin
                go = 1'b0;
                if (c != hdr_magic(mpos_next))
                begin
                    err_next   = ST_BAD_HEADER;
                    phase_next = PH_FAILED;
                end
                else
                begin
                    mpos_next = mpos_next + 3'd1;
                    if (mpos_next == MAGIC_LEN)
                    begin
                        phase_next = PH_HDR_VERSION;
                        num_next   = '0;
                    end
                end
            end
            if (go && phase_next == PH_HDR_VERSION)
            begin
                if (dig)
                begin
                    num_next = mul10_add(num_next, d);
                    go       = 1'b0;
                end
                else if (num_next != version_reg)
                begin
                    err_next   = ST_BAD_HEADER;
                    phase_next = PH_FAILED;
                    go         = 1'b0;
                end
                else
                    phase_next = PH_HDR_REST;
            end
            if (go && phase_next == PH_HDR_REST)
            begin
                if (c == CH_NL)
                    phase_next = PH_LINE_START;
                go = 1'b0;
            end
            if (go && phase_next == PH_LINE_START)
            begin
                if (c == CH_NL)
                    go = 1'b0;
                else
                begin
                    line_next  = '0;
                    recip_next = '0;
                    uops_next  = '0;
                    flags_next = '0;
                    best_next  = '0;
                    num_next   = '0;
                    colon_next = '0;
                    mpos_next  = '0;
                    phase_next = dig ? PH_MAP_FORM : PH_CLASS_PREFIX;
                end
            end
            if (go && phase_next == PH_CLASS_PREFIX)
            begin
                go = 1'b0;
                if (mpos_next < CLASS_WORD_LEN && c == class_word(mpos_next))
                begin
                    mpos_next = mpos_next + 3'd1;
                    if (mpos_next == CLASS_WORD_LEN)
                        phase_next = PH_CID;
                end
                else
                    phase_next = PH_SKIP_LINE;
            end
            if (go && phase_next == PH_CID)
            begin
                if (dig)
                begin
                    line_next = mul10_add(line_next, d);
                    go        = 1'b0;
                end
                else
                begin
                    milli_next = '0;
                    fpos_next  = '0;
                    neg_next   = 1'b0;
                    num_next   = '0;
                    phase_next = PH_RECIP_SIGN;
                    if (c == CH_BAR)
                        go = 1'b0;
                end
            end
            if (go && phase_next == PH_RECIP_SIGN)
            begin
                phase_next = PH_RECIP_WHOLE;
                if (c == CH_MINUS)
                begin
                    neg_next = 1'b1;
                    go       = 1'b0;
                end
            end
            if (go && phase_next == PH_RECIP_WHOLE)
            begin
                if (dig)
                begin
                    milli_next = mul10_add(milli_next, 4'd0) + 32'(d) * MILLI;
                    go         = 1'b0;
                end
                else if (c == CH_DOT)
                begin
                    phase_next = PH_RECIP_FRAC;
                    go         = 1'b0;
                end
                else
                begin
                    recip_next = neg_next ? 32'd0 : milli_next;
                    phase_next = PH_SKIP1;
                end
            end
            if (go && phase_next == PH_RECIP_FRAC)
            begin
                if (dig)
                begin
                    if (fpos_next < FRAC_DIGITS)
                    begin
                        milli_next = milli_next + frac_add;
                        fpos_next  = fpos_next + 2'd1;
                    end
                    go = 1'b0;
                end
                else
                begin
                    recip_next = neg_next ? 32'd0 : milli_next;
                    phase_next = PH_SKIP1;
                end
            end
            if (go && phase_next == PH_SKIP1)
            begin
                if (c == CH_BAR)
                begin
                    phase_next = PH_UOPS;
                    num_next   = '0;
                    colon_next = '0;
                end
                go = 1'b0;
            end
            if (go && phase_next == PH_UOPS)
            begin
                if (dig)
                begin
                    num_next = mul10_add(num_next, d);
                    go       = 1'b0;
                end
                else
                begin
                    uops_next  = num_next[15:0];
                    phase_next = PH_SKIP2;
                end
            end
            if (go && phase_next == PH_SKIP2)
            begin
                if (c == CH_BAR)
                begin
                    phase_next = PH_MICRO;
                    num_next   = '0;
                    colon_next = '0;
                end
                go = 1'b0;
            end
            if (go && phase_next == PH_MICRO)
            begin
                if (dig)
                begin
                    num_next = mul10_add(num_next, d);
                    go       = 1'b0;
                end
                else
                begin
                    if (num_next != '0)
                        flags_next[0] = 1'b1;
                    phase_next = PH_SKIP3;
                end
            end
            if (go && phase_next == PH_SKIP3)
            begin
                if (c == CH_BAR)
                begin
                    phase_next = PH_FUSE;
                    num_next   = '0;
                    colon_next = '0;
                end
                go = 1'b0;
            end
            if (go && phase_next == PH_FUSE)
            begin
                if (dig)
                begin
                    num_next = mul10_add(num_next, d);
                    go       = 1'b0;
                end
                else
                begin
                    if (num_next != '0)
                        flags_next[1] = 1'b1;
                    phase_next = PH_SKIP4;
                end
            end
            if (go && (phase_next == PH_SKIP4 || phase_next == PH_SKIP5))
            begin
                if (c == CH_BAR)
                begin
                    phase_next = (phase_next == PH_SKIP4) ? PH_SKIP5 : PH_LAT_SCAN;
                    num_next   = '0;
                    colon_next = '0;
                end
                go = 1'b0;
            end
            if (go && phase_next == PH_LAT_SIGN)
            begin
                phase_next = PH_LAT_WHOLE;
                if (c == CH_MINUS)
                begin
                    neg_next = 1'b1;
                    go       = 1'b0;
                end
            end
            if (go && phase_next == PH_LAT_WHOLE)
            begin
                if (dig)
                begin
                    milli_next = mul10_add(milli_next, 4'd0) + 32'(d) * MILLI;
                    go         = 1'b0;
                end
                else if (c == CH_DOT)
                begin
                    phase_next = PH_LAT_FRAC;
                    go         = 1'b0;
                end
                else
                begin
                    mv = neg_next ? 32'd0 : milli_next;
                    if (mv > best_next)
                        best_next = mv;
                    phase_next = PH_LAT_SCAN;
                end
            end
            if (go && phase_next == PH_LAT_FRAC)
            begin
                if (dig)
                begin
                    if (fpos_next < FRAC_DIGITS)
                    begin
                        milli_next = milli_next + frac_add;
                        fpos_next  = fpos_next + 2'd1;
                    end
                    go = 1'b0;
                end
                else
                begin
                    mv = neg_next ? 32'd0 : milli_next;
                    if (mv > best_next)
                        best_next = mv;
                    phase_next = PH_LAT_SCAN;
                end
            end
            // latency scan sits after the latency decimal: it ends that chain
            if (go && phase_next == PH_LAT_SCAN)
            begin
                go = 1'b0;
                if (c == CH_COMMA)
                    colon_next = '0;
                else if (c == CH_BAR)
                    phase_next = PH_CLASS_TAIL;
                else if (c == CH_COLON)
                begin
                    if (colon_next < COLON_MAX)
                        colon_next = colon_next + 3'd1;
                    if (colon_next == LAT_COLON)
                    begin
                        milli_next = '0;
                        fpos_next  = '0;
                        neg_next   = 1'b0;
                        num_next   = '0;
                        phase_next = PH_LAT_SIGN;
                    end
                end
            end
            if (go && phase_next == PH_MAP_FORM)
            begin
                go = 1'b0;
                if (dig)
                    line_next = mul10_add(line_next, d);
                else if (c == CH_BAR)
                begin
                    num_next   = '0;
                    phase_next = PH_MAP_CLASS;
                end
                else
                    phase_next = PH_SKIP_LINE;
            end
            if (go && phase_next == PH_MAP_CLASS)
            begin
                go = 1'b0;
                if (dig)
                    num_next = mul10_add(num_next, d);
                else
                    phase_next = PH_MAP_TAIL;
            end

            // end of text checks on the header, and close of an open line
            if (text.end_of_text)
            begin
                if (phase_next == PH_HDR_PREFIX)
                    err_next = ST_BAD_HEADER;
                else if (phase_next == PH_HDR_VERSION && num_next != version_reg)
                    err_next = ST_BAD_HEADER;
                else if (in_line(phase_next))
                    do_end = 1'b1;
            end

            // line close: flush the open field, then emit or flag capacity
            if (do_end)
            begin
                mv = neg_next ? 32'd0 : milli_next;
                if (phase_next >= PH_RECIP_SIGN && phase_next <= PH_RECIP_FRAC)
                    recip_next = mv;
                if (phase_next == PH_UOPS)
                    uops_next = num_next[15:0];
                if (phase_next == PH_MICRO && num_next != '0)
                    flags_next[0] = 1'b1;
                if (phase_next == PH_FUSE && num_next != '0)
                    flags_next[1] = 1'b1;
                if (phase_next >= PH_LAT_SIGN && phase_next <= PH_LAT_FRAC && mv > best_next)
                    best_next = mv;

                if (phase_next >= PH_CID && phase_next <= PH_CLASS_TAIL)
                begin
                    if (line_next >= 32'(class_cap_reg))
                    begin
                        err_next   = ST_NO_SPACE;
                        phase_next = PH_FAILED;
                    end
                    else
                    begin
                        rec_valid                  = 1'b1;
                        rec.kind                   = KIND_CLASS;
                        rec.index                  = line_next[15:0];
                        rec.recip_throughput_milli = recip_next;
                        rec.uop_count              = uops_next;
                        rec.microcoded             = flags_next[0];
                        rec.macro_fusible          = flags_next[1];
                        rec.latency_milli          = best_next;
                        id_plus1 = {1'b0, line_next[15:0]} + 17'd1;
                        if (id_plus1 > {1'b0, high_next})
                            high_next = id_plus1[15:0];
                        phase_next = PH_LINE_START;
                    end
                end
                else if (phase_next == PH_MAP_CLASS || phase_next == PH_MAP_TAIL)
                begin
                    if (line_next >= 32'(form_cap_reg) || num_next >= 32'(class_cap_reg))
                    begin
                        err_next   = ST_NO_SPACE;
                        phase_next = PH_FAILED;
                    end
                    else
                    begin
                        rec_valid        = 1'b1;
                        rec.kind         = KIND_MAP;
                        rec.index        = line_next[15:0];
                        rec.mapped_class = num_next[15:0];
                        mapcnt_next      = mapcnt_next + 32'd1;
                        phase_next       = PH_LINE_START;
                    end
                end
                else
                    phase_next = PH_LINE_START;
            end

            if (text.end_of_text)
            begin
                stat_valid         = 1'b1;
                stat.kind          = KIND_STATUS;
                stat.status        = err_next;
                stat.class_total   = high_next;
                stat.mapping_total = mapcnt_next;
                // next run starts from scratch
                phase_next  = PH_HDR_PREFIX;
                mpos_next   = '0;
                colon_next  = '0;
                num_next    = '0;
                milli_next  = '0;
                fpos_next   = '0;
                neg_next    = 1'b0;
                line_next   = '0;
                recip_next  = '0;
                uops_next   = '0;
                flags_next  = '0;
                best_next   = '0;
                high_next   = '0;
                mapcnt_next = '0;
                err_next    = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_PREFIX;
            mpos_reg   <= '0;
            colon_reg  <= '0;
            num_reg    <= '0;
            milli_reg  <= '0;
            fpos_reg   <= '0;
            neg_reg    <= 1'b0;
            line_reg   <= '0;
            recip_reg  <= '0;
            uops_reg   <= '0;
            flags_reg  <= '0;
            best_reg   <= '0;
            high_reg   <= '0;
            mapcnt_reg <= '0;
            err_reg    <= ST_OK;
        end
        else
        begin
            phase_reg  <= phase_next;
            mpos_reg   <= mpos_next;
            colon_reg  <= colon_next;
            num_reg    <= num_next;
            milli_reg  <= milli_next;
            fpos_reg   <= fpos_next;
            neg_reg    <= neg_next;
            line_reg   <= line_next;
            recip_reg  <= recip_next;
            uops_reg   <= uops_next;
            flags_reg  <= flags_next;
            best_reg   <= best_next;
            high_reg   <= high_next;
            mapcnt_reg <= mapcnt_next;
            err_reg    <= err_next;
        end
    end

    // output buffer: record first, then status
    assign push_cnt = {1'b0, rec_valid} + {1'b0, stat_valid};

    always_ff @(posedge clk)
    begin
        if (rec_valid)
            fifo_reg[wr_ptr_reg] <= rec;
        if (stat_valid)
            fifo_reg[rec_valid ? wr_ptr_reg + 2'd1 : wr_ptr_reg] <= stat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    assign result.valid                  = (cnt_reg != 3'd0);
    assign result.kind                   = fifo_reg[rd_ptr_reg].kind;
    assign result.status                 = fifo_reg[rd_ptr_reg].status;
    assign result.index                  = fifo_reg[rd_ptr_reg].index;
    assign result.mapped_class           = fifo_reg[rd_ptr_reg].mapped_class;
    assign result.recip_throughput_milli = fifo_reg[rd_ptr_reg].recip_throughput_milli;
    assign result.uop_count              = fifo_reg[rd_ptr_reg].uop_count;
    assign result.microcoded             = fifo_reg[rd_ptr_reg].microcoded;
    assign result.macro_fusible          = fifo_reg[rd_ptr_reg].macro_fusible;
    assign result.latency_milli          = fifo_reg[rd_ptr_reg].latency_milli;
    assign result.class_total            = fifo_reg[rd_ptr_reg].class_total;
    assign result.mapping_total          = fifo_reg[rd_ptr_reg].mapping_total;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("output buffer overflow");

    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_text |=> phase_reg == PH_HDR_PREFIX && err_reg == ST_OK)
        else $error("run did not restart after last word");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED && !(accept && text.end_of_text) |=> phase_reg == PH_FAILED)
        else $error("left failed state before end of text");

    a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED |-> err_reg != ST_OK)
        else $error("failed state without error code");
`endif

endmodule
